// ----- rtl/core/xdec_pkg.sv -----
// ----------------------------------------------------------------------------
// xdec_pkg: shared types and constants of the escaped-text XOR decryptor
// Holds the key store geometry, the action format passed from the parser to
// the key engine, and the action queue sizing.
// ----------------------------------------------------------------------------
package xdec_pkg;

  // Key and prefix store geometry.
  localparam int KEY_DEPTH = 1024;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);
  localparam int LEN_W     = 11;

  // Action queue between parser and key engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  // Kinds of work the parser hands to the key engine.
  typedef enum logic [1:0] {
    ACT_PREFIX  = 2'd0,
    ACT_EMIT    = 2'd1,
    ACT_NEWLINE = 2'd2
  } act_kind_t;

  // One action: a prefix write, a keyed byte, or a line end.
  typedef struct packed {
    act_kind_t         kind;
    logic [KEY_AW-1:0] addr;
    logic [7:0]        data;
    logic              wr_key;
  } act_t;

  // Up to two actions pushed per accepted item.
  typedef struct packed {
    logic [1:0] n;
    act_t       a0;
    act_t       a1;
  } q_push_t;

endpackage

// ----- rtl/core/xdec_front.sv -----
// ----------------------------------------------------------------------------
// xdec_front: escape parser and key position tracker
// Accepts one item per cycle unless full, decodes the escape syntax, tracks
// the key position and key recovery window, and pushes up to two actions.
// ----------------------------------------------------------------------------
module xdec_front import xdec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_op,
  input  logic [9:0]       in_index,
  input  logic [7:0]       in_value,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_key_length,
  input  logic             room,
  input  logic             clearing,
  output q_push_t          push
);

  // Item operation codes.
  localparam logic [1:0] OP_PREFIX  = 2'd0;
  localparam logic [1:0] OP_CHAR    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [1:0] {
    M_NORMAL = 2'd0,
    M_ESC    = 2'd1,
    M_HEX1   = 2'd2,
    M_HEX2   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PC_EMIT = 2'd0,
    PC_ESC  = 2'd1,
    PC_NL   = 2'd2,
    PC_SKIP = 2'd3
  } pclass_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] d;
  } hex_t;

  typedef struct packed {
    logic [KEY_AW-1:0] p;
    logic              wr;
    logic [KEY_AW-1:0] pos_nxt;
    logic              win_nxt;
  } emit_t;

  // Value of one hex digit character.
  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.d     = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.valid = 1'b1;
      h.d     = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.valid = 1'b1;
      h.d     = 4'(c - 8'h37);
    end
    return h;
  endfunction

  // How a character outside an escape is handled.
  function automatic pclass_t plain_class(input logic [7:0] c);
    pclass_t k;
    if (c == CH_BSLASH) begin
      k = PC_ESC;
    end else if (c == CH_LF) begin
      k = PC_NL;
    end else if (c == CH_CR || c == CH_NUL) begin
      k = PC_SKIP;
    end else begin
      k = PC_EMIT;
    end
    return k;
  endfunction

  // Key position step for one emitted byte, with wrap and window exit.
  function automatic emit_t emit_step(input logic [KEY_AW-1:0] pos,
                                      input logic              win,
                                      input logic              first,
                                      input logic [LEN_W-1:0]  kl);
    emit_t           e;
    logic [LEN_W-1:0] nx;
    e.p   = pos;
    e.win_nxt = win;
    if ({{(LEN_W-KEY_AW){1'b0}}, pos} >= kl) begin
      e.p       = '0;
      e.win_nxt = 1'b0;
    end
    e.wr = first & e.win_nxt;
    nx   = {{(LEN_W-KEY_AW){1'b0}}, e.p} + LEN_W'(1);
    if (nx >= kl) begin
      nx        = '0;
      e.win_nxt = 1'b0;
    end
    e.pos_nxt = nx[KEY_AW-1:0];
    return e;
  endfunction

  mode_t             mode_r, mode_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic              stop_r, stop_nxt;
  logic [KEY_AW-1:0] pos_r, pos_nxt;
  logic              first_r, first_nxt;
  logic              win_r, win_nxt;
  logic              skip_r, skip_nxt;
  logic [LEN_W-1:0]  klen_r;

  logic              accept;
  logic              do_plain;
  logic [1:0]        tk_n;
  logic              tk0_nl, tk1_nl;
  logic [7:0]        tk0_byte, tk1_byte;
  hex_t              hv;
  pclass_t           cls;
  logic              term;
  emit_t             es0, es1;
  logic [KEY_AW-1:0] pos_mid;
  logic              win_mid;

  assign in_full = ~room | clearing;
  assign accept  = in_push & ~in_full;
  assign hv      = hex_val(in_value);
  assign cls     = plain_class(in_value);
  assign term    = (in_value == CH_LF) || (in_value == CH_CR) || (in_value == CH_NUL);

  // Parse one item into up to two tokens, then place emitted bytes on the key.
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    stop_nxt  = stop_r;
    pos_nxt   = pos_r;
    first_nxt = first_r;
    win_nxt   = win_r;
    skip_nxt  = skip_r;
    do_plain  = 1'b0;
    tk_n      = 2'd0;
    tk0_nl    = 1'b0;
    tk1_nl    = 1'b0;
    tk0_byte  = '0;
    tk1_byte  = '0;
    push      = '0;
    es0       = '0;
    es1       = '0;
    pos_mid   = '0;
    win_mid   = 1'b0;

    if (accept) begin
      case (in_op)
        OP_PREFIX: begin
          push.n         = 2'd1;
          push.a0.kind   = ACT_PREFIX;
          push.a0.addr   = in_index;
          push.a0.data   = in_value;
          push.a0.wr_key = 1'b0;
        end
        OP_RESTART: begin
          mode_nxt  = M_NORMAL;
          acc_nxt   = '0;
          stop_nxt  = 1'b0;
          pos_nxt   = '0;
          first_nxt = 1'b1;
          win_nxt   = 1'b1;
          skip_nxt  = 1'b0;
        end
        OP_CHAR: begin
          if (skip_r) begin
            if (in_value == CH_LF) begin
              tk0_nl = 1'b1;
              tk_n   = 2'd1;
            end
          end else begin
            case (mode_r)
              M_ESC: begin
                mode_nxt = M_NORMAL;
                case (in_value)
                  CH_T: begin
                    tk0_byte = CH_TAB;
                    tk_n     = 2'd1;
                  end
                  CH_N: begin
                    tk0_byte = CH_LF;
                    tk_n     = 2'd1;
                  end
                  CH_R: begin
                    tk0_byte = CH_CR;
                    tk_n     = 2'd1;
                  end
                  CH_BSLASH: begin
                    tk0_byte = CH_BSLASH;
                    tk_n     = 2'd1;
                  end
                  CH_X: begin
                    mode_nxt = M_HEX1;
                    acc_nxt  = '0;
                    stop_nxt = 1'b0;
                  end
                  default: begin
                    // Unknown escape: the backslash stands for itself.
                    tk0_byte = CH_BSLASH;
                    tk_n     = 2'd1;
                    do_plain = 1'b1;
                  end
                endcase
              end
              M_HEX1: begin
                if (term) begin
                  mode_nxt = M_NORMAL;
                  tk0_byte = acc_r;
                  tk_n     = 2'd1;
                  do_plain = 1'b1;
                end else begin
                  if (hv.valid) begin
                    acc_nxt = {4'h0, hv.d};
                  end else begin
                    stop_nxt = 1'b1;
                  end
                  mode_nxt = M_HEX2;
                end
              end
              M_HEX2: begin
                mode_nxt = M_NORMAL;
                if (term) begin
                  tk0_byte = acc_r;
                  tk_n     = 2'd1;
                  do_plain = 1'b1;
                end else begin
                  if (hv.valid && !stop_r) begin
                    acc_nxt = {acc_r[3:0], hv.d};
                  end
                  tk0_byte = acc_nxt;
                  tk_n     = 2'd1;
                end
              end
              default: begin
                do_plain = 1'b1;
              end
            endcase

            // Ordinary character handling, after any byte the escape produced.
            if (do_plain) begin
              case (cls)
                PC_ESC: begin
                  mode_nxt = M_ESC;
                end
                PC_NL: begin
                  if (tk_n == 2'd0) begin
                    tk0_nl = 1'b1;
                  end else begin
                    tk1_nl = 1'b1;
                  end
                  tk_n = tk_n + 2'd1;
                end
                PC_SKIP: begin
                  skip_nxt = 1'b1;
                end
                default: begin
                  if (tk_n == 2'd0) begin
                    tk0_byte = in_value;
                  end else begin
                    tk1_byte = in_value;
                  end
                  tk_n = tk_n + 2'd1;
                end
              endcase
            end
          end
          push.n = tk_n;
        end
        default: begin
        end
      endcase

      // First token.
      pos_mid = pos_nxt;
      win_mid = win_nxt;
      if (tk_n != 2'd0) begin
        if (tk0_nl) begin
          push.a0.kind = ACT_NEWLINE;
          push.a0.data = CH_LF;
          pos_mid      = '0;
          win_mid      = 1'b0;
          first_nxt    = 1'b0;
          skip_nxt     = 1'b0;
          mode_nxt     = M_NORMAL;
        end else begin
          es0            = emit_step(pos_nxt, win_nxt, first_r, klen_r);
          push.a0.kind   = ACT_EMIT;
          push.a0.addr   = es0.p;
          push.a0.data   = tk0_byte;
          push.a0.wr_key = es0.wr;
          pos_mid        = es0.pos_nxt;
          win_mid        = es0.win_nxt;
        end
      end
      pos_nxt = pos_mid;
      win_nxt = win_mid;

      // Second token.
      if (tk_n == 2'd2) begin
        if (tk1_nl) begin
          push.a1.kind = ACT_NEWLINE;
          push.a1.data = CH_LF;
          pos_nxt      = '0;
          win_nxt      = 1'b0;
          first_nxt    = 1'b0;
          skip_nxt     = 1'b0;
          mode_nxt     = M_NORMAL;
        end else begin
          es1            = emit_step(pos_mid, win_mid, first_r, klen_r);
          push.a1.kind   = ACT_EMIT;
          push.a1.addr   = es1.p;
          push.a1.data   = tk1_byte;
          push.a1.wr_key = es1.wr;
          pos_nxt        = es1.pos_nxt;
          win_nxt        = es1.win_nxt;
        end
      end
    end
  end

  // Parser state and the clamped key length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_NORMAL;
      acc_r   <= '0;
      stop_r  <= 1'b0;
      pos_r   <= '0;
      first_r <= 1'b1;
      win_r   <= 1'b1;
      skip_r  <= 1'b0;
      klen_r  <= LEN_W'(1);
    end else begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      stop_r  <= stop_nxt;
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      win_r   <= win_nxt;
      skip_r  <= skip_nxt;
      if (cfg_we) begin
        if (cfg_key_length == '0) begin
          klen_r <= LEN_W'(1);
        end else if (cfg_key_length > LEN_W'(KEY_DEPTH)) begin
          klen_r <= LEN_W'(KEY_DEPTH);
        end else begin
          klen_r <= cfg_key_length;
        end
      end
    end
  end

endmodule

// ----- rtl/core/xdec_queue.sv -----
// ----------------------------------------------------------------------------
// xdec_queue: action queue between parser and key engine
// Takes up to two actions per cycle; hands out one per cycle in order on pop.
// ----------------------------------------------------------------------------
module xdec_queue import xdec_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  input  logic    pop,
  output logic    room,
  output logic    valid,
  output act_t    head
);

  act_t            ent_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] head_r, head_nxt;
  logic [Q_AW-1:0] tail_r, tail_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic [Q_AW-1:0] tail_p1;

  // Room for a full pair of actions.
  assign room    = count_r <= Q_CW'(QUEUE_DEPTH - 2);
  assign valid   = count_r != '0;
  assign head    = ent_r[head_r];
  assign tail_p1 = tail_r + Q_AW'(1);

  // Pointer and fill bookkeeping.
  always_comb begin
    head_nxt  = pop ? head_r + Q_AW'(1) : head_r;
    tail_nxt  = tail_r + Q_AW'(push.n);
    count_nxt = count_r + Q_CW'(push.n) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      ent_r[tail_r] <= push.a0;
    end
    if (push.n == 2'd2) begin
      ent_r[tail_p1] <= push.a1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(QUEUE_DEPTH))
    else $error("action queue holds more entries than its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("action queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room)
    else $error("actions pushed without room for a pair");

endmodule

// ----- rtl/core/xdec_back.sv -----
// ----------------------------------------------------------------------------
// xdec_back: key engine with key and prefix stores
// Executes one action per cycle when not stalled: prefix writes, keyed bytes
// with key recovery, and line ends. Holds the out port's result register.
// ----------------------------------------------------------------------------
module xdec_back import xdec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  act_t       q_head,
  output logic       q_pop,
  output logic       clearing,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_line_end
);

  logic [7:0]        key_mem    [KEY_DEPTH];
  logic [7:0]        prefix_mem [KEY_DEPTH];

  logic              clr_active_r;
  logic [KEY_AW-1:0] clr_cnt_r;

  logic              s2_v_r;
  logic              s2_nl_r;
  logic              s2_wr_r;
  logic [KEY_AW-1:0] s2_p_r;
  logic [7:0]        s2_b_r;
  logic [7:0]        key_rd_r;
  logic [7:0]        prefix_rd_r;
  logic              byp_r;
  logic [7:0]        byp_data_r;

  logic              s2_free;
  logic              advance;
  logic              rd_en;
  logic              pw_en;
  logic              out_take;
  logic              kw_en;
  logic [7:0]        kw_data;
  logic [7:0]        key_eff;

  // Stage control: the result register refills as soon as it is taken.
  assign out_take = out_pop & s2_v_r;
  assign s2_free  = ~s2_v_r | out_pop;
  assign advance  = s2_free & q_valid & ~clr_active_r;
  assign q_pop    = advance;
  assign rd_en    = advance & (q_head.kind != ACT_PREFIX);
  assign pw_en    = advance & (q_head.kind == ACT_PREFIX);
  assign clearing = clr_active_r;

  // Key recovery write goes out when the byte leaves.
  assign kw_en   = out_take & ~s2_nl_r & s2_wr_r;
  assign kw_data = s2_b_r ^ prefix_rd_r;
  assign key_eff = byp_r ? byp_data_r : key_rd_r;

  // Result: a recovered byte decrypts to the prefix byte itself.
  assign out_empty    = ~s2_v_r;
  assign out_line_end = s2_nl_r;
  always_comb begin
    if (s2_nl_r) begin
      out_byte = s2_b_r;
    end else if (s2_wr_r) begin
      out_byte = prefix_rd_r;
    end else begin
      out_byte = s2_b_r ^ key_eff;
    end
  end

  // Clearing pass over both stores after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + KEY_AW'(1);
      if (clr_cnt_r == KEY_AW'(KEY_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= rd_en;
    end
  end

  // Result register payload and forwarding of a same-cycle key write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2_nl_r    <= q_head.kind == ACT_NEWLINE;
      s2_wr_r    <= q_head.wr_key;
      s2_p_r     <= q_head.addr;
      s2_b_r     <= q_head.data;
      byp_r      <= kw_en && (s2_p_r == q_head.addr);
      byp_data_r <= kw_data;
    end
  end

  // Key store.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      key_mem[clr_cnt_r] <= '0;
    end else if (kw_en) begin
      key_mem[s2_p_r] <= kw_data;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[q_head.addr];
    end
  end

  // Prefix store.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      prefix_mem[clr_cnt_r] <= '0;
    end else if (pw_en) begin
      prefix_mem[q_head.addr] <= q_head.data;
    end
    if (rd_en) begin
      prefix_rd_r <= prefix_mem[q_head.addr];
    end
  end

  a_no_work_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !advance)
    else $error("action executed during the clearing pass");

  a_key_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    kw_en |-> (s2_v_r && !s2_nl_r && !clr_active_r))
    else $error("key write without a keyed byte in the result register");

  a_clear_length: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> $past(clr_cnt_r) == KEY_AW'(KEY_DEPTH - 1))
    else $error("clearing pass ended before covering the stores");

endmodule

// ----- rtl/core/escaped_text_repeating_xor_decrypt_unit.sv -----
// ----------------------------------------------------------------------------
// escaped_text_repeating_xor_decrypt_unit: escaped-text repeating-key XOR
// decryptor with key recovery from a known plaintext prefix.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock cycle while in_full is low and delivers
// one result per clock cycle while results are popped; the single key engine,
// with one key store read per byte, sets that result rate. An accepted
// character passes through the action queue and the result register before
// its result appears. A four-entry action queue lets the parser keep taking
// items while a result waits to be popped. After reset the unit runs a
// clearing pass over every entry of the key and prefix stores, during which
// full stays high; key length writes are taken at any time but should be made
// while the unit is idle.
module escaped_text_repeating_xor_decrypt_unit import xdec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_op,
  input  logic [9:0]       in_index,
  input  logic [7:0]       in_value,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_byte,
  output logic             out_line_end,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_key_length
);

  q_push_t push;
  logic    room;
  logic    q_valid;
  act_t    q_head;
  logic    q_pop;
  logic    clearing;

  // Parser front end.
  xdec_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_key_length (cfg_key_length),
    .room           (room),
    .clearing       (clearing),
    .push           (push)
  );

  // Action queue.
  xdec_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .room  (room),
    .valid (q_valid),
    .head  (q_head)
  );

  // Key engine and result register.
  xdec_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_line_end (out_line_end)
  );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the escaped-text repeating-key XOR decryptor
// Streams prefix loads, restarts and escaped ciphertext lines into the unit,
// predicts every plaintext byte and line end, and checks each result in order
// across several key lengths and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import xdec_pkg::*;

  // Item operations and parser modes.
  typedef enum logic [1:0] {
    OP_PREFIX  = 2'd0,
    OP_CHAR    = 2'd1,
    OP_RESTART = 2'd2,
    OP_SPARE   = 2'd3
  } text_op_t;

  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0,
    PM_ESC    = 2'd1,
    PM_HEX1   = 2'd2,
    PM_HEX2   = 2'd3
  } parse_mode_t;

  // Characters with a meaning to the escape parser.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_X      = "x";

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 12;
  localparam int NUM_PHASES  = 9;

  typedef struct {
    logic [1:0] op;
    logic [9:0] index;
    logic [7:0] value;
  } text_item_t;

  typedef struct {
    logic [7:0] data;
    logic       line_end;
  } plain_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [1:0]       in_op = 2'd0;
  logic [9:0]       in_index = 10'd0;
  logic [7:0]       in_value = 8'd0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [7:0]       out_byte;
  logic             out_line_end;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_key_length = '0;

  // Pending ciphertext items and expected plaintext results.
  text_item_t stream_q[$];
  plain_res_t plain_q[$];
  text_item_t next_item;
  plain_res_t want;

  // Shadow state of the decryptor.
  logic [7:0]  key_mem[KEY_DEPTH];
  logic [7:0]  prefix_mem[KEY_DEPTH];
  int unsigned key_len_cfg = 1;
  parse_mode_t mode = PM_NORMAL;
  logic [7:0]  hex_acc = 8'd0;
  logic        hex_stop = 1'b0;
  int unsigned kpos = 0;
  logic        first_ln = 1'b1;
  logic        in_window = 1'b1;
  logic        skipping = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned lines_seen = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cnt = 0;

  escaped_text_repeating_xor_decrypt_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_line_end   (out_line_end),
    .cfg_we         (cfg_we),
    .cfg_key_length (cfg_key_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < KEY_DEPTH; i++) begin
      key_mem[i] = 8'd0;
      prefix_mem[i] = 8'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Decryption predictor
  // ---------------------------------------------------------------------------

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic is_line_stop(logic [7:0] c);
    return c == CH_LF || c == CH_CR || c == CH_NUL;
  endfunction

  // Emit one decoded byte under the key; during the first line it also
  // recovers the key byte from the known prefix.
  function automatic void emit_byte(logic [7:0] b);
    int unsigned klen;
    int unsigned p;
    klen = (key_len_cfg == 0) ? 1 : ((key_len_cfg > KEY_DEPTH) ? KEY_DEPTH : key_len_cfg);
    p = kpos;
    if (p >= klen) begin
      p = 0;
      in_window = 1'b0;
    end
    if (first_ln && in_window) key_mem[p] = b ^ prefix_mem[p];
    plain_q.push_back('{data: b ^ key_mem[p], line_end: 1'b0});
    p++;
    if (p >= klen) begin
      p = 0;
      in_window = 1'b0;
    end
    kpos = p;
  endfunction

  function automatic void line_break();
    kpos = 0;
    first_ln = 1'b0;
    in_window = 1'b0;
    skipping = 1'b0;
    mode = PM_NORMAL;
    plain_q.push_back('{data: CH_LF, line_end: 1'b1});
  endfunction

  function automatic void plain_char(logic [7:0] c);
    if (c == CH_BSLASH) mode = PM_ESC;
    else if (c == CH_LF) line_break();
    else if (c == CH_CR || c == CH_NUL) skipping = 1'b1;
    else emit_byte(c);
  endfunction

  // Advance the shadow state by one accepted item.
  function automatic void decrypt_item(logic [1:0] op, logic [9:0] idx, logic [7:0] c);
    int d;
    case (op)
      OP_PREFIX: prefix_mem[idx] = c;
      OP_RESTART: begin
        mode = PM_NORMAL;
        hex_acc = 8'd0;
        hex_stop = 1'b0;
        kpos = 0;
        first_ln = 1'b1;
        in_window = 1'b1;
        skipping = 1'b0;
      end
      OP_CHAR: begin
        if (skipping) begin
          if (c == CH_LF) line_break();
        end else begin
          case (mode)
            PM_ESC: begin
              mode = PM_NORMAL;
              if (c == CH_T) emit_byte(CH_TAB);
              else if (c == CH_N) emit_byte(CH_LF);
              else if (c == CH_R) emit_byte(CH_CR);
              else if (c == CH_BSLASH) emit_byte(CH_BSLASH);
              else if (c == CH_X) begin
                mode = PM_HEX1;
                hex_acc = 8'd0;
                hex_stop = 1'b0;
              end else begin
                emit_byte(CH_BSLASH);
                plain_char(c);
              end
            end
            PM_HEX1: begin
              if (is_line_stop(c)) begin
                mode = PM_NORMAL;
                emit_byte(hex_acc);
                plain_char(c);
              end else begin
                d = hex_digit(c);
                if (d >= 0) hex_acc = 8'(d);
                else hex_stop = 1'b1;
                mode = PM_HEX2;
              end
            end
            PM_HEX2: begin
              mode = PM_NORMAL;
              if (is_line_stop(c)) begin
                emit_byte(hex_acc);
                plain_char(c);
              end else begin
                d = hex_digit(c);
                if (d >= 0 && !hex_stop) hex_acc = {hex_acc[3:0], 4'(d)};
                emit_byte(hex_acc);
              end
            end
            default: plain_char(c);
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic void push_text(text_op_t op, int unsigned idx, int unsigned val);
    stream_q.push_back('{op: op, index: 10'(idx), value: 8'(val)});
  endfunction

  // Text characters carry a random index so its bits toggle as well.
  function automatic void push_char(logic [7:0] c);
    push_text(OP_CHAR, $urandom_range(1023), c);
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    c = 8'($urandom_range(126, 32));
    return (c == CH_BSLASH) ? 8'("A") : c;
  endfunction

  function automatic logic [7:0] pick_hex();
    int unsigned d;
    d = $urandom_range(15);
    if (d < 10) return 8'(int'("0") + d);
    return 8'(($urandom_range(1) ? int'("a") : int'("A")) + d - 10);
  endfunction

  // One escaped ciphertext line, closed by a line feed.
  function automatic void add_cipher_line(int unsigned max_len);
    int unsigned n;
    int unsigned r;
    logic [7:0] c;
    n = $urandom_range(max_len);
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 58) begin
        push_char(pick_plain());
      end else if (r < 68) begin
        push_char(CH_BSLASH);
        case ($urandom_range(3))
          0: push_char(CH_T);
          1: push_char(CH_N);
          2: push_char(CH_R);
          default: push_char(CH_BSLASH);
        endcase
      end else if (r < 80) begin
        // Hex escape: two positions, each a digit or a random non-terminator.
        push_char(CH_BSLASH);
        push_char(CH_X);
        repeat (2) begin
          if ($urandom_range(99) < 75) begin
            push_char(pick_hex());
          end else begin
            c = 8'($urandom_range(255, 1));
            push_char((c == CH_LF || c == CH_CR) ? 8'("g") : c);
          end
        end
      end else if (r < 85) begin
        push_char(CH_BSLASH);
        push_char(8'($urandom_range(255)));
      end else if (r < 90) begin
        push_char(8'($urandom_range(255)));
      end else if (r < 93) begin
        // Hex escape cut short by a terminator.
        push_char(CH_BSLASH);
        push_char(CH_X);
        if ($urandom_range(1)) push_char(pick_hex());
        case ($urandom_range(2))
          0: push_char(CH_LF);
          1: push_char(CH_CR);
          default: push_char(CH_NUL);
        endcase
      end else begin
        push_text(text_op_t'($urandom_range(3)), $urandom_range(1023), $urandom_range(255));
      end
    end
    push_char(CH_LF);
  endfunction

  // Random traffic for one key length: an optional restart with a fresh
  // prefix and first line, more lines, and a few characters left mid-line.
  function automatic void build_phase(int unsigned len);
    int unsigned klen;
    int unsigned goal;
    klen = (len == 0) ? 1 : ((len > KEY_DEPTH) ? KEY_DEPTH : len);
    goal = stream_q.size() + 70;
    if (klen > 100 || $urandom_range(1)) begin
      push_text(OP_RESTART, $urandom_range(1023), $urandom_range(255));
      for (int unsigned i = 0; i < klen && i < 24; i++) begin
        push_text(OP_PREFIX, i, $urandom_range(255));
      end
      add_cipher_line((klen + 4 > 120) ? 120 : klen + 4);
    end
    push_text(OP_PREFIX, $urandom_range(1023), $urandom_range(255));
    while (stream_q.size() < goal) add_cipher_line(30);
    repeat ($urandom_range(6)) push_char(pick_plain());
  endfunction

  // Wait until nothing is queued, in flight or expected, then let any
  // result-free items settle inside the unit.
  task automatic drain();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_push || plain_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer: reset, key length settings, directed and random traffic
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned len_plan[NUM_PHASES];
    int unsigned len;
    len_plan = '{3, 0, 16, 2, 1024, 1, 2047, 5, 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) drain();
      len = (ph == NUM_PHASES - 1) ? $urandom_range(40, 1) : len_plan[ph];
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_key_length <= LEN_W'(len);
      key_len_cfg = len;
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (ph == 0) begin
        // Directed opening with a three-byte key: prefix extremes, key
        // recovery, hex escapes with two digits, none and a cut-off one,
        // an unknown escape, the spare op, a skipped tail and a restart.
        push_text(OP_PREFIX, 0, 8'h00);
        push_text(OP_PREFIX, 1023, 8'hFF);
        push_text(OP_PREFIX, 1, 8'h4B);
        push_text(OP_PREFIX, 2, 8'hA5);
        push_char(8'hFF);
        push_char(CH_BSLASH); push_char(CH_X); push_char("F"); push_char("f");
        push_char(CH_BSLASH); push_char("q");
        push_char(CH_BSLASH); push_char(CH_X); push_char("g"); push_char("1");
        push_char(CH_BSLASH); push_char(CH_X); push_char("7"); push_char(CH_LF);
        push_text(OP_SPARE, 1023, 8'hFF);
        push_char(CH_BSLASH); push_char(CH_T);
        push_char(CH_NUL); push_char("z"); push_char(CH_LF);
        push_text(OP_RESTART, 0, 8'h00);
      end
      build_phase(len);
    end
    drain();
    $display("Ran %0d items through %0d key length settings and four idling patterns;",
             items_taken, NUM_PHASES);
    $display("checked %0d plaintext results, %0d of them line ends.", results_seen, lines_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued items and predicts each accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        decrypt_item(in_op, in_index, in_value);
        items_taken++;
      end
      if (!in_push || !in_full) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = stream_q.pop_front();
          in_push <= 1'b1;
          in_op <= next_item.op;
          in_index <= next_item.index;
          in_value <= next_item.value;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  function automatic void report_mismatch(string what, int expv, int actv);
    mismatches++;
    if (mismatches <= 20) begin
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, what, expv, actv);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: pops results and compares them with the oldest expected byte
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (out_line_end === 1'b1) lines_seen++;
        if (plain_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 20) begin
            $display("%0t: unexpected result, expected none, actual byte 0x%02h line_end %b",
                     $time, out_byte, out_line_end);
          end
        end else begin
          want = plain_q.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", want.data, out_byte);
          if (out_line_end !== want.line_end) begin
            report_mismatch("out_line_end", want.line_end, out_line_end);
          end
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

endmodule
